### design/keepalive_heartbeat_monitor_defines.svh
// ----------------------------------------------------------------------------
// Keep-alive monitor assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef KEEPALIVE_HEARTBEAT_MONITOR_DEFINES_SVH
`define KEEPALIVE_HEARTBEAT_MONITOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define KAHM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset
`define KAHM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KAHM_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define KAHM_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif

`endif

### design/kahm_pkg.sv
// ----------------------------------------------------------------------------
// Keep-alive monitor package
// Item kind codes, configuration register indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package kahm_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned TMO_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Input item kinds
  localparam logic [KIND_W-1:0] KIND_TICK       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEEPALIVE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OTHER      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DISCONNECT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  // Configuration reset values
  localparam logic             RST_ENABLED     = 1'b0;
  localparam logic             RST_SERVER_MODE = 1'b1;
  localparam logic [TMO_W-1:0] RST_TIMEOUT     = 16'd10;

endpackage

### design/kahm_ifs.sv
// ----------------------------------------------------------------------------
// Keep-alive monitor channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface kahm_in_if;
  logic                         valid;
  logic                         ready;
  logic [kahm_pkg::KIND_W-1:0]  kind;
  logic [kahm_pkg::FIELD_W-1:0] current_time;
  logic [kahm_pkg::FIELD_W-1:0] received_number;

  modport source (output valid, kind, current_time, received_number, input ready);
  modport sink   (input valid, kind, current_time, received_number, output ready);
endinterface

interface kahm_out_if;
  logic                         valid;
  logic                         ready;
  logic                         send_valid;
  logic [kahm_pkg::FIELD_W-1:0] send_number;
  logic                         handled;
  logic                         expired;

  modport source (output valid, send_valid, send_number, handled, expired, input ready);
  modport sink   (input valid, send_valid, send_number, handled, expired, output ready);
endinterface

### design/keepalive_heartbeat_monitor.sv
// Pipeline: an accepted item passes through the input register, then the result register.
// Throughput: 1 item per cycle unless the result slot stalls; the timer state is updated
// in the same cycle the item moves from the input register to the result register.
// Reset: synchronous active-low rst_n clears both pipeline valids, the timers,
// flags and packet counter, and loads the configuration defaults.
// ----------------------------------------------------------------------------
// Keep-alive heartbeat monitor
// Server sends numbered keep-alives per timeout window; client echoes them.
// ----------------------------------------------------------------------------
`include "keepalive_heartbeat_monitor_defines.svh"

module keepalive_heartbeat_monitor #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kahm_in_if.sink                           in_if,
  kahm_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [kahm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kahm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers
  logic                        enabled_r;
  logic                        server_mode_r;
  logic [kahm_pkg::TMO_W-1:0]  timeout_r;

  // Input register
  logic                          s1_valid_r;
  logic [kahm_pkg::KIND_W-1:0]   s1_kind_r;
  logic [kahm_pkg::FIELD_W-1:0]  s1_time_r;
  logic [kahm_pkg::FIELD_W-1:0]  s1_rxno_r;

  // Timer state
  logic [TIME_BITS-1:0]          last_sent_r, last_sent_nxt;
  logic [TIME_BITS-1:0]          last_rcvd_r, last_rcvd_nxt;
  logic                          awaiting_r, awaiting_nxt;
  logic                          required_r, required_nxt;
  logic [kahm_pkg::FIELD_W-1:0]  counter_r, counter_nxt;

  // Result register
  logic                          out_valid_r;
  logic                          send_valid_r, send_valid_nxt;
  logic [kahm_pkg::FIELD_W-1:0]  send_number_r, send_number_nxt;
  logic                          handled_r, handled_nxt;
  logic                          expired_r, expired_nxt;

  logic                 out_free;
  logic                 s1_fire;
  logic                 in_fire;
  logic                 active;
  logic [63:0]          now_w;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] sent_elapsed;
  logic [TIME_BITS-1:0] exp_sent_elapsed;
  logic [TIME_BITS-1:0] exp_rcvd_elapsed;
  logic [63:0]          tmo_w;
  logic                 sent_passed;

  // Handshake: result slot frees when empty or taken this cycle
  assign out_free    = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;
  assign in_fire     = in_if.valid && in_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.send_valid  = send_valid_r;
  assign out_if.send_number = send_number_r;
  assign out_if.handled     = handled_r;
  assign out_if.expired     = expired_r;

  // Time taken modulo 2^TIME_BITS
  assign now_w  = 64'(s1_time_r);
  assign now    = now_w[TIME_BITS-1:0];
  assign tmo_w  = 64'(timeout_r);
  assign active = enabled_r && (timeout_r != '0);

  assign sent_elapsed = now - last_sent_r;
  assign sent_passed  = 64'(sent_elapsed) >= tmo_w;

  // Compute next state and the result for the item in the input register
  always_comb begin
    last_sent_nxt   = last_sent_r;
    last_rcvd_nxt   = last_rcvd_r;
    awaiting_nxt    = awaiting_r;
    required_nxt    = required_r;
    counter_nxt     = counter_r;
    send_valid_nxt  = 1'b0;
    send_number_nxt = '0;
    handled_nxt     = 1'b0;
    if (s1_kind_r == kahm_pkg::KIND_DISCONNECT) begin
      last_sent_nxt = '0;
      last_rcvd_nxt = '0;
      awaiting_nxt  = 1'b0;
      required_nxt  = 1'b0;
    end else if (active) begin
      case (s1_kind_r)
        kahm_pkg::KIND_TICK: begin
          if (server_mode_r) begin
            if (last_sent_r == '0) begin
              last_sent_nxt = now;
            end else if (sent_passed) begin
              send_valid_nxt  = 1'b1;
              send_number_nxt = counter_r;
              counter_nxt     = counter_r + 1'b1;
              awaiting_nxt    = 1'b1;
              last_sent_nxt   = now;
            end
          end
        end
        kahm_pkg::KIND_KEEPALIVE: begin
          handled_nxt = 1'b1;
          if (server_mode_r) begin
            last_sent_nxt = now;
            last_rcvd_nxt = now;
            awaiting_nxt  = 1'b0;
          end else begin
            required_nxt    = 1'b1;
            counter_nxt     = s1_rxno_r;
            send_valid_nxt  = 1'b1;
            send_number_nxt = s1_rxno_r;
            last_rcvd_nxt   = now;
          end
        end
        default: begin
          // other packets leave the state alone
        end
      endcase
    end
  end

  // Expiry is judged on the state left by this item
  assign exp_sent_elapsed = now - last_sent_nxt;
  assign exp_rcvd_elapsed = now - last_rcvd_nxt;

  always_comb begin
    expired_nxt = 1'b0;
    if (active) begin
      if (server_mode_r) begin
        expired_nxt = awaiting_nxt && (64'(exp_sent_elapsed) >= tmo_w);
      end else begin
        expired_nxt = required_nxt && (last_rcvd_nxt != '0) &&
                      (64'(exp_rcvd_elapsed) >= tmo_w);
      end
    end
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r     <= kahm_pkg::RST_ENABLED;
      server_mode_r <= kahm_pkg::RST_SERVER_MODE;
      timeout_r     <= kahm_pkg::RST_TIMEOUT;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      last_sent_r   <= '0;
      last_rcvd_r   <= '0;
      awaiting_r    <= 1'b0;
      required_r    <= 1'b0;
      counter_r     <= '0;
    end else begin
      // Configuration writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          kahm_pkg::CFG_ENABLED:     enabled_r     <= cfg_wdata[0];
          kahm_pkg::CFG_SERVER_MODE: server_mode_r <= cfg_wdata[0];
          kahm_pkg::CFG_TIMEOUT:     timeout_r     <= cfg_wdata;
          default: ;
        endcase
      end
      // Advance the pipeline valids
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      // Commit state for the item leaving the input register
      if (s1_fire) begin
        last_sent_r <= last_sent_nxt;
        last_rcvd_r <= last_rcvd_nxt;
        awaiting_r  <= awaiting_nxt;
        required_r  <= required_nxt;
        counter_r   <= counter_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_if.kind;
      s1_time_r <= in_if.current_time;
      s1_rxno_r <= in_if.received_number;
    end
    if (s1_fire) begin
      send_valid_r  <= send_valid_nxt;
      send_number_r <= send_number_nxt;
      handled_r     <= handled_nxt;
      expired_r     <= expired_nxt;
    end
  end

  // Assertions
  `KAHM_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid_r, in_if.ready, "input stalled with empty result slot")
  `KAHM_ASSERT_NXT(a_disc_clears, clk, rst_n, s1_fire && (s1_kind_r == kahm_pkg::KIND_DISCONNECT), !awaiting_r && !required_r && (last_sent_r == '0) && (last_rcvd_r == '0), "disconnect did not clear timers")
  `KAHM_ASSERT_NXT(a_send_counts, clk, rst_n, s1_fire && server_mode_r && send_valid_nxt, awaiting_r && (counter_r == $past(counter_r) + 1'b1), "server send did not arm wait and count")
  `KAHM_ASSERT_IMP(a_idle_number, clk, rst_n, out_valid_r && !send_valid_r, send_number_r == '0, "send number set without a send")

endmodule
